// ----- design/rtpm_pkg.sv -----
// rtpm_pkg: shared types and constants for the rating tolerance pair matcher
// used by rating_tolerance_pair_matcher and its checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rtpm_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = 7;
    localparam int WAIT_W = 32;
    localparam int WIDEN_W = 10;
    localparam int TOL_W = 16;
    localparam int PROD_W = WAIT_W + WIDEN_W;

    localparam logic [TOL_W-1:0] BASE_RESET = 16'd100;
    localparam logic [WIDEN_W-1:0] WIDEN_RESET = 10'd10;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MATCH  = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_WIDEN = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] entry_id;
        logic [15:0] rating;
        logic [31:0] time_seconds;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [6:0]  queue_position;
        logic [6:0]  entry_count;
        logic [63:0] first_id;
        logic [15:0] first_rating;
        logic [31:0] first_time;
        logic [63:0] second_id;
        logic [15:0] second_rating;
        logic [31:0] second_time;
    } t_out;

    typedef struct packed {
        logic [63:0] id;
        logic [15:0] rating;
        logic [31:0] tstamp;
    } t_entry;

endpackage
`default_nettype wire

// ----- design/rating_tolerance_pair_matcher.sv -----
// rating_tolerance_pair_matcher: ordered waiting table with add, remove, match, query
// depends on rtpm_pkg
//
// One item is taken when start is high and busy is low; busy stays high until its
// result strobes on o_result_valid for one cycle (the receiver cannot stall). All
// work runs through one entry memory and one compare/subtract unit, one entry
// visited at a time. Add and query scan the held entries, remove searches and
// then moves each entry above the found one down, and match runs a read and
// tolerance step per first entry (S_IRD, S_ILAT, S_MUL, S_TOL), a compare per
// later entry, then the compaction of the matched pair. A match on fewer than two
// entries, an add to a full table or a remove or query on an empty table is
// answered in the next cycle. The table needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module rating_tolerance_pair_matcher
    import rtpm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_in         i_item,
    output logic             o_result_valid,
    output t_out             o_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_FRD, S_FCMP, S_ADDW, S_IRD, S_ILAT, S_MUL, S_TOL,
        S_JRD, S_JCMP, S_DCHK, S_DRD, S_DWR
    } t_state;

    t_state            r_state;
    logic [TOL_W-1:0]  r_base;
    logic [WIDEN_W-1:0] r_widen;
    logic [CW-1:0]     r_occ;
    logic [CW-1:0]     r_k, r_i, r_j, r_m;
    logic              r_second_del;
    logic [1:0]        r_cmd;
    logic [63:0]       r_key;
    logic [15:0]       r_rating;
    logic [31:0]       r_now;
    t_entry            r_ent_a, r_ent_b;
    logic [WAIT_W-1:0] r_wait;
    logic [PROD_W-1:0] r_prod;
    logic [TOL_W-1:0]  r_tol;
    logic              r_strobe;
    t_out              r_res;

    // entry memory, one write and one registered read port
    t_entry            mem [MAX_ENTRIES];
    t_entry            r_rd;
    logic [AW-1:0]     raddr, waddr;
    logic              we;
    t_entry            wdata;

    always_comb begin
        raddr = r_k[AW-1:0];
        we    = 1'b0;
        waddr = r_m[AW-1:0];
        wdata = r_rd;
        unique case (r_state)
            S_IRD:   raddr = r_i[AW-1:0];
            S_JRD:   raddr = r_j[AW-1:0];
            S_DRD:   raddr = AW'(r_m + 1'b1);
            S_DWR:   we = 1'b1;
            S_ADDW: begin
                we    = 1'b1;
                waddr = r_occ[AW-1:0];
                wdata = '{id: r_key, rating: r_rating, tstamp: r_now};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[raddr];
    end

    // shared compare/subtract unit
    logic [15:0]       diff;
    logic [PROD_W:0]   tol_sum;
    logic [CW:0]       k_next, j_next, m_next, i_two;
    always_comb begin
        diff    = (r_ent_a.rating > r_rd.rating) ? r_ent_a.rating - r_rd.rating
                                                 : r_rd.rating - r_ent_a.rating;
        tol_sum = {1'b0, r_prod} + (PROD_W+1)'(r_base);
        k_next  = {1'b0, r_k} + 1'b1;
        j_next  = {1'b0, r_j} + 1'b1;
        m_next  = {1'b0, r_m} + 1'b1;
        i_two   = {1'b0, r_i} + 2'd2;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_strobe;
    assign o_result       = r_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= BASE_RESET;
            r_widen <= WIDEN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_BASE)  r_base  <= i_cfg_data;
            if (i_cfg_index == REG_WIDEN) r_widen <= i_cfg_data[WIDEN_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_occ        <= '0;
            r_strobe     <= 1'b0;
            r_second_del <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd    <= i_item.cmd;
                        r_key    <= i_item.entry_id;
                        r_rating <= i_item.rating;
                        r_now    <= i_item.time_seconds;
                        r_k      <= '0;
                        r_i      <= '0;
                        r_res    <= '{entry_count: r_occ, default: '0};
                        if (i_item.cmd == CMD_MATCH) begin
                            if (r_occ < CW'(2)) r_strobe <= 1'b1;
                            else r_state <= S_IRD;
                        end else if (i_item.cmd == CMD_ADD &&
                                     r_occ == CW'(MAX_ENTRIES)) begin
                            r_strobe <= 1'b1;
                        end else if (r_occ == '0) begin
                            if (i_item.cmd == CMD_ADD) r_state <= S_ADDW;
                            else r_strobe <= 1'b1;
                        end else begin
                            r_state <= S_FRD;
                        end
                    end
                end
                S_FRD: r_state <= S_FCMP;
                S_FCMP: begin
                    if (r_rd.id == r_key) begin
                        unique case (r_cmd)
                            CMD_REMOVE: begin
                                r_m          <= r_k;
                                r_second_del <= 1'b0;
                                r_state      <= S_DCHK;
                            end
                            CMD_QUERY: begin
                                r_res.queue_position <= k_next[CW-1:0];
                                r_strobe <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                            default: begin
                                r_strobe <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        endcase
                    end else if (k_next < {1'b0, r_occ}) begin
                        r_k     <= k_next[CW-1:0];
                        r_state <= S_FRD;
                    end else if (r_cmd == CMD_ADD) begin
                        r_state <= S_ADDW;
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_ADDW: begin
                    r_occ             <= r_occ + 1'b1;
                    r_res.ok          <= 1'b1;
                    r_res.entry_count <= r_occ + 1'b1;
                    r_strobe          <= 1'b1;
                    r_state           <= S_IDLE;
                end
                // tolerance of first entry
                S_IRD: r_state <= S_ILAT;
                S_ILAT: begin
                    r_ent_a <= r_rd;
                    r_wait  <= (r_now > r_rd.tstamp) ? r_now - r_rd.tstamp : '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_wait * r_widen;
                    r_state <= S_TOL;
                end
                S_TOL: begin
                    r_tol   <= (tol_sum > (PROD_W+1)'(16'hFFFF)) ? 16'hFFFF
                                                                 : tol_sum[TOL_W-1:0];
                    r_j     <= r_i + 1'b1;
                    r_state <= S_JRD;
                end
                // scan later entries
                S_JRD: r_state <= S_JCMP;
                S_JCMP: begin
                    if (diff <= r_tol) begin
                        r_ent_b      <= r_rd;
                        r_m          <= r_j;
                        r_second_del <= 1'b1;
                        r_state      <= S_DCHK;
                    end else if (j_next < {1'b0, r_occ}) begin
                        r_j     <= j_next[CW-1:0];
                        r_state <= S_JRD;
                    end else if (i_two < {1'b0, r_occ}) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_IRD;
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                // compaction: shift entries above r_m down by one
                S_DCHK: begin
                    if (m_next < {1'b0, r_occ}) begin
                        r_state <= S_DRD;
                    end else begin
                        r_occ <= r_occ - 1'b1;
                        if (r_second_del) begin
                            r_second_del <= 1'b0;
                            r_m          <= r_i;
                        end else begin
                            if (r_cmd == CMD_MATCH) begin
                                r_res.ok            <= 1'b1;
                                r_res.first_id      <= r_ent_a.id;
                                r_res.first_rating  <= r_ent_a.rating;
                                r_res.first_time    <= r_ent_a.tstamp;
                                r_res.second_id     <= r_ent_b.id;
                                r_res.second_rating <= r_ent_b.rating;
                                r_res.second_time   <= r_ent_b.tstamp;
                            end
                            r_res.entry_count <= r_occ - 1'b1;
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_DRD: r_state <= S_DWR;
                S_DWR: begin
                    r_m     <= m_next[CW-1:0];
                    r_state <= S_DCHK;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- design/rtpm_checker.sv -----
// rtpm_checker: port-level assertions for rating_tolerance_pair_matcher
// depends on rtpm_pkg; bound to rating_tolerance_pair_matcher below
`timescale 1ns / 1ps
`default_nettype none
module rtpm_checker
    import rtpm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_result_valid,
    input wire t_out o_result
);

    // an accepted item keeps the block busy next cycle unless it finished at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted item neither busy nor answered");

    // a result is shown only once the block has gone idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result while busy");

    // count never exceeds table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.entry_count <= CW'(MAX_ENTRIES)))
        else $error("entry count out of range");

    // a position is only reported without ok
    a_pos_no_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.queue_position != '0) |-> !o_result.ok)
        else $error("position with ok set");

    // no result without a preceding busy period or accept
    a_no_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> ($past(busy) || $past(start)))
        else $error("result without item");

endmodule

bind rating_tolerance_pair_matcher rtpm_checker u_rtpm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_result_valid(o_result_valid), .o_result(o_result)
);
`default_nettype wire

// ----- bench/tb_rating_tolerance_pair_matcher.sv -----
// tb_rating_tolerance_pair_matcher: self-checking bench for the pair matcher
// depends on rtpm_pkg and rating_tolerance_pair_matcher
`timescale 1ns / 1ps
`default_nettype none

// table mirror and store of pending results
class matcher_scoreboard;
    rtpm_pkg::t_entry slots[$];
    logic [15:0] base_tol;
    logic [9:0]  widen;
    rtpm_pkg::t_out pending[$];
    int errors;
    int pair_hits;

    function void clear();
        slots.delete();
        pending.delete();
        base_tol = rtpm_pkg::BASE_RESET;
        widen = rtpm_pkg::WIDEN_RESET;
        errors = 0;
        pair_hits = 0;
    endfunction

    function int locate(logic [63:0] id);
        for (int k = 0; k < slots.size(); k++)
            if (slots[k].id == id) return k + 1;
        return 0;
    endfunction

    // compute and queue the result of one accepted item
    function void note_item(rtpm_pkg::t_in it);
        rtpm_pkg::t_out r;
        rtpm_pkg::t_entry e;
        logic [63:0] tol;
        logic [31:0] waited;
        logic [15:0] diff;
        bit found;
        int k;
        r = '0;
        found = 0;
        case (rtpm_pkg::t_cmd'(it.cmd))
            rtpm_pkg::CMD_ADD: begin
                if (slots.size() < rtpm_pkg::MAX_ENTRIES && locate(it.entry_id) == 0) begin
                    e.id = it.entry_id;
                    e.rating = it.rating;
                    e.tstamp = it.time_seconds;
                    slots.insert(slots.size(), e);
                    r.ok = 1'b1;
                end
            end
            rtpm_pkg::CMD_REMOVE: begin
                k = locate(it.entry_id);
                while (k != 0) begin
                    slots.delete(k - 1);
                    k = locate(it.entry_id);
                end
            end
            rtpm_pkg::CMD_MATCH: begin
                for (int i = 0; i < slots.size() && !found; i++) begin
                    waited = (it.time_seconds > slots[i].tstamp) ?
                             it.time_seconds - slots[i].tstamp : 32'd0;
                    tol = 64'(base_tol) + 64'(waited) * 64'(widen);
                    if (tol > 64'hFFFF) tol = 64'hFFFF;
                    for (int j = i + 1; j < slots.size(); j++) begin
                        diff = (slots[i].rating > slots[j].rating) ?
                               slots[i].rating - slots[j].rating :
                               slots[j].rating - slots[i].rating;
                        if (64'(diff) <= tol) begin
                            r.first_id = slots[i].id;
                            r.first_rating = slots[i].rating;
                            r.first_time = slots[i].tstamp;
                            r.second_id = slots[j].id;
                            r.second_rating = slots[j].rating;
                            r.second_time = slots[j].tstamp;
                            slots.delete(j);
                            slots.delete(i);
                            r.ok = 1'b1;
                            found = 1;
                            pair_hits++;
                            break;
                        end
                    end
                end
            end
            default: r.queue_position = 7'(locate(it.entry_id));
        endcase
        r.entry_count = 7'(slots.size());
        pending.insert(pending.size(), r);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(rtpm_pkg::t_out got);
        rtpm_pkg::t_out exp_r;
        if (pending.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.ok !== exp_r.ok) begin
            $error("ok exp %0h got %0h", exp_r.ok, got.ok); errors++;
        end
        if (got.queue_position !== exp_r.queue_position) begin
            $error("queue_position exp %0d got %0d", exp_r.queue_position,
                   got.queue_position); errors++;
        end
        if (got.entry_count !== exp_r.entry_count) begin
            $error("entry_count exp %0d got %0d", exp_r.entry_count, got.entry_count);
            errors++;
        end
        if (got.first_id !== exp_r.first_id) begin
            $error("first_id exp %0h got %0h", exp_r.first_id, got.first_id); errors++;
        end
        if (got.first_rating !== exp_r.first_rating) begin
            $error("first_rating exp %0h got %0h", exp_r.first_rating, got.first_rating);
            errors++;
        end
        if (got.first_time !== exp_r.first_time) begin
            $error("first_time exp %0h got %0h", exp_r.first_time, got.first_time);
            errors++;
        end
        if (got.second_id !== exp_r.second_id) begin
            $error("second_id exp %0h got %0h", exp_r.second_id, got.second_id);
            errors++;
        end
        if (got.second_rating !== exp_r.second_rating) begin
            $error("second_rating exp %0h got %0h", exp_r.second_rating,
                   got.second_rating); errors++;
        end
        if (got.second_time !== exp_r.second_time) begin
            $error("second_time exp %0h got %0h", exp_r.second_time, got.second_time);
            errors++;
        end
    endfunction
endclass

module tb_rating_tolerance_pair_matcher;
    import rtpm_pkg::*;

    localparam int LIMIT_CYCLES = 40000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_item;
    logic        o_result_valid;
    t_out        o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    matcher_scoreboard board;
    int cycle_count;
    int item_count;
    bit calm;
    logic [63:0] recent_ids[8];

    rating_tolerance_pair_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_result_valid(o_result_valid), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result checking and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_result_valid) board.check_result(o_result);
        if (cycle_count > LIMIT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one item, held until taken; start stays high for the next item
    task automatic send_item(t_cmd cmd, logic [63:0] id, logic [15:0] rating,
                             logic [31:0] tsec);
        t_in it;
        it.cmd = cmd;
        it.entry_id = id;
        it.rating = rating;
        it.time_seconds = tsec;
        if (!calm) begin
            while ($urandom_range(99) < 14) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_item(it);
        item_count++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_BASE) board.base_tol = val;
        else board.widen = val[9:0];
    endtask

    // random id, often a recent one so remove, query and duplicates hit
    function automatic logic [63:0] pick_id();
        if ($urandom_range(99) < 55) return recent_ids[$urandom_range(7)];
        return {$urandom, $urandom};
    endfunction

    task automatic random_item(int add_bias);
        logic [63:0] id;
        int sel;
        sel = $urandom_range(99);
        id = pick_id();
        if (sel < add_bias) begin
            id = {$urandom, $urandom};
            recent_ids[$urandom_range(7)] = id;
            send_item(CMD_ADD, id, 16'($urandom), $urandom_range(2000));
        end else if (sel < add_bias + 12) begin
            send_item(CMD_ADD, id, 16'($urandom), $urandom);
        end else if (sel < add_bias + 24) begin
            send_item(CMD_REMOVE, id, 16'($urandom), $urandom);
        end else if (sel < add_bias + 40) begin
            send_item(CMD_QUERY, id, 16'($urandom), $urandom);
        end else begin
            send_item(CMD_MATCH, id, 16'($urandom), $urandom_range(3000));
        end
    endtask

    initial begin
        board = new();
        board.clear();
        cycle_count = 0;
        item_count = 0;
        calm = 0;
        for (int k = 0; k < 8; k++) recent_ids[k] = {$urandom, $urandom};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_BASE;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, duplicates, matching
        send_item(CMD_MATCH, '1, '1, '1);
        send_item(CMD_QUERY, '1, 16'd0, 32'd0);
        send_item(CMD_ADD, 64'd0, 16'd0, 32'd0);
        send_item(CMD_ADD, '1, '1, '1);
        send_item(CMD_ADD, '1, 16'd5, 32'd5);
        send_item(CMD_QUERY, '1, 16'd0, 32'd0);
        send_item(CMD_MATCH, 64'd7, 16'd0, 32'd0);
        send_item(CMD_MATCH, 64'd7, 16'd0, '1);
        send_item(CMD_REMOVE, 64'h1234, 16'd0, 32'd0);
        send_item(CMD_ADD, 64'h5555_AAAA_5555_AAAA, 16'd1000, 32'd100);
        send_item(CMD_ADD, 64'hAAAA_5555_AAAA_5555, 16'd1100, 32'd100);
        send_item(CMD_MATCH, 64'd0, 16'd0, 32'd50);
        send_item(CMD_ADD, 64'd9, 16'd1000, 32'd100);
        send_item(CMD_MATCH, 64'd0, 16'd0, 32'd50);
        send_item(CMD_REMOVE, 64'd9, 16'd0, 32'd0);
        // fill to capacity, then a refused add
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            calm = 1;
            send_item(CMD_ADD, 64'(k + 100), 16'(k * 1000), 32'(k));
        end
        send_item(CMD_ADD, 64'd5000, 16'd1, 32'd1);
        send_item(CMD_QUERY, 64'd163, 16'd0, 32'd0);
        send_item(CMD_MATCH, 64'd0, 16'd0, 32'd0);
        calm = 0;
        drain();

        // config extremes, then random phases
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_BASE, 16'd0); write_reg(REG_WIDEN, 16'd0); end
                1: begin write_reg(REG_BASE, 16'hFFFF); write_reg(REG_WIDEN, 16'd1023); end
                2: begin write_reg(REG_BASE, 16'd100); write_reg(REG_WIDEN, 16'd10); end
                3: begin write_reg(REG_BASE, 16'd20); write_reg(REG_WIDEN, 16'd1023); end
                default: begin
                    write_reg(REG_BASE, 16'($urandom_range(3000)));
                    write_reg(REG_WIDEN, 16'($urandom_range(1023)));
                end
            endcase
            calm = (phase == 2);
            for (int n = 0; n < 300; n++) random_item(phase == 4 ? 55 : 30);
            calm = 0;
            drain();
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("covered %0d items, %0d pairs found, over six tolerance settings",
                 item_count, board.pair_hits);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/rtpm_pkg.sv
design/rating_tolerance_pair_matcher.sv
design/rtpm_checker.sv
bench/tb_rating_tolerance_pair_matcher.sv
